// ----- sv/svo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svo_pkg: shared types for the shadowcast visibility block
// Fraction width, queued tile record, shadow entry, sequencer states and compares.
// ----------------------------------------------------------------------------
package svo_pkg;

  localparam int FW = 5;

  typedef logic [FW-1:0] frac_w_t;

  typedef struct packed {
    frac_w_t lo_n;
    frac_w_t lo_d;
    frac_w_t hi_n;
    frac_w_t hi_d;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic              row_ok;
    logic              on_map;
    logic              blocked;
    entry_t            span;
    logic signed [4:0] off_x;
    logic signed [4:0] off_y;
  } tile_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INS,
    ST_FULL_RD,
    ST_FULL_CHK,
    ST_DONE
  } state_t;

  function automatic logic frac_le(frac_w_t an, frac_w_t ad, frac_w_t bn, frac_w_t bd);
    logic [2*FW-1:0] l;
    logic [2*FW-1:0] r;
    l = an * bd;
    r = bn * ad;
    return l <= r;
  endfunction

  function automatic logic frac_lt(frac_w_t an, frac_w_t ad, frac_w_t bn, frac_w_t bd);
    logic [2*FW-1:0] l;
    logic [2*FW-1:0] r;
    l = an * bd;
    r = bn * ad;
    return l < r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/svo_tile_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svo_tile_if: input tile channel
// Valid/ready handshake carrying one scanned tile.
// ----------------------------------------------------------------------------
interface svo_tile_if;
  logic       valid;
  logic       ready;
  logic       start_octant;
  logic [2:0] octant;
  logic [3:0] row;
  logic [3:0] col;
  logic       on_map;
  logic       blocked;

  modport source (output valid, start_octant, octant, row, col, on_map, blocked,
                  input ready);
  modport sink (input valid, start_octant, octant, row, col, on_map, blocked,
                output ready);
endinterface
`default_nettype wire

// ----- sv/svo_res_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svo_res_if: result channel
// Valid/ready handshake carrying one visibility result.
// ----------------------------------------------------------------------------
interface svo_res_if;
  logic              valid;
  logic              ready;
  logic              visible;
  logic signed [4:0] offset_x;
  logic signed [4:0] offset_y;
  logic              fully_shadowed;
  logic              list_overflow;

  modport source (output valid, visible, offset_x, offset_y, fully_shadowed,
                  list_overflow, input ready);
  modport sink (input valid, visible, offset_x, offset_y, fully_shadowed,
                list_overflow, output ready);
endinterface
`default_nettype wire

// ----- sv/shadowcast_visibility_octant.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shadowcast_visibility_octant: shadowcasting field of view, one octant
// Tiles enter on tile_in in octant scan order; one result per tile leaves on
// res_out with visibility, transformed offsets, the full-shadow flag and a
// list overflow flag. start_octant on a tile clears the shadow list first.
// The intake classifies tiles into a two-entry queue; the list sequencer
// works on one tile at a time out of a shadow memory with one read and one write port.
// Tiles off the map, out of range or under full shadow skip the list and
// go straight to the result register. Others scan the stored shadows,
// each with a read and a check step, stopping at one that contains the
// tile; then a decision, entry moves on an insert or a double merge, an
// update and a full-shadow check follow.
// Reset empties the list, clears the full-shadow flag and the result valid, and drops queued tiles.
// A stalled receiver holds the result register; the queue keeps taking
// tiles until both slots fill, then tile_in.ready falls.
// ----------------------------------------------------------------------------
module shadowcast_visibility_octant #(
  parameter int MAX_ROW     = 15,
  parameter int MAX_SHADOWS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  svo_tile_if.sink   tile_in,
  svo_res_if.source  res_out
);
  import svo_pkg::*;

  tile_t q_data;
  logic  q_valid;
  logic  q_ready;

  svo_front #(.MAX_ROW(MAX_ROW)) u_front (
    .clk     (clk),
    .rst     (rst),
    .tile_in (tile_in),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  svo_back #(.MAX_SHADOWS(MAX_SHADOWS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .res_out (res_out)
  );

endmodule
`default_nettype wire

// ----- sv/svo_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svo_front: tile intake
// Classifies each tile, forms its slope span and offsets, and queues it.
// ----------------------------------------------------------------------------
module svo_front #(
  parameter int MAX_ROW = 15
) (
  input  wire logic           clk,
  input  wire logic           rst,
  svo_tile_if.sink            tile_in,
  output svo_pkg::tile_t      q_data,
  output logic                q_valid,
  input  wire logic           q_ready
);
  import svo_pkg::*;

  tile_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  tile_t       t;
  logic        push;
  logic        pop;
  logic signed [4:0] sc;
  logic signed [4:0] sr;

  assign tile_in.ready = (fill != 2'd2);
  assign push = tile_in.valid && tile_in.ready;
  assign q_valid = (fill != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = slot[rd_ptr];

  always_comb begin
    sc = signed'({1'b0, tile_in.col});
    sr = signed'({1'b0, tile_in.row});
    t.start   = tile_in.start_octant;
    t.row_ok  = (tile_in.row != 4'd0) && ({1'b0, tile_in.row} <= 5'(MAX_ROW));
    t.on_map  = tile_in.on_map;
    t.blocked = tile_in.blocked;
    t.span.lo_n = {1'b0, tile_in.col};
    t.span.lo_d = {1'b0, tile_in.row} + 5'd2;
    t.span.hi_n = {1'b0, tile_in.col} + 5'd1;
    t.span.hi_d = {1'b0, tile_in.row} + 5'd1;
    case (tile_in.octant)
      3'd0: begin t.off_x = sc;  t.off_y = -sr; end
      3'd1: begin t.off_x = sr;  t.off_y = -sc; end
      3'd2: begin t.off_x = sr;  t.off_y = sc;  end
      3'd3: begin t.off_x = sc;  t.off_y = sr;  end
      3'd4: begin t.off_x = -sc; t.off_y = sr;  end
      3'd5: begin t.off_x = -sr; t.off_y = sc;  end
      3'd6: begin t.off_x = -sr; t.off_y = -sc; end
      default: begin t.off_x = -sc; t.off_y = -sr; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= t;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ----- sv/svo_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svo_back: shadow list sequencer
// Scans the stored shadows, merges or inserts new ones, and drives results.
// ----------------------------------------------------------------------------
module svo_back #(
  parameter int MAX_SHADOWS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire svo_pkg::tile_t q_data,
  input  wire logic           q_valid,
  output logic                q_ready,
  svo_res_if.source           res_out
);
  import svo_pkg::*;

  localparam int AW = (MAX_SHADOWS > 1) ? $clog2(MAX_SHADOWS) : 1;
  localparam int CW = $clog2(MAX_SHADOWS + 1);

  entry_t          mem [MAX_SHADOWS];
  entry_t          rdata;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   waddr;
  entry_t          wdata;
  logic            we;

  state_t          state;
  state_t          state_next;
  tile_t           cur;
  logic [CW-1:0]   cnt;
  logic            full;
  logic [CW-1:0]   i;
  logic [CW-1:0]   idx;
  logic            found;
  logic            dn;
  entry_t          prev_e;
  entry_t          next_e;
  logic            vis;
  logic            ovf;
  logic            res_valid;

  logic            take;
  logic            scan_need;
  logic [CW-1:0]   cnt_eff;
  logic            contain;
  logic            at_lo;
  logic [CW-1:0]   idx_eff;
  logic            has_prev;
  logic            has_next;
  logic            res_load;

  assign take     = (state == ST_IDLE) && q_valid;
  assign cnt_eff  = q_data.start ? '0 : cnt;
  assign scan_need = q_data.row_ok && q_data.on_map && !(q_data.start ? 1'b0 : full);
  assign contain  = frac_le(rdata.lo_n, rdata.lo_d, cur.span.lo_n, cur.span.lo_d) &&
                    frac_le(cur.span.hi_n, cur.span.hi_d, rdata.hi_n, rdata.hi_d);
  assign at_lo    = frac_le(cur.span.lo_n, cur.span.lo_d, rdata.lo_n, rdata.lo_d);
  assign idx_eff  = found ? idx : cnt;
  assign has_prev = (idx_eff != '0) &&
                    frac_lt(cur.span.lo_n, cur.span.lo_d, prev_e.hi_n, prev_e.hi_d);
  assign has_next = found &&
                    frac_lt(next_e.lo_n, next_e.lo_d, cur.span.hi_n, cur.span.hi_d);
  assign res_load = (state == ST_DONE) && (!res_valid || res_out.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (!scan_need) state_next = ST_DONE;
          else if (cnt_eff == '0) state_next = ST_DECIDE;
          else state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (contain) state_next = ST_DONE;
        else if (i + 1'b1 == cnt) state_next = ST_DECIDE;
        else state_next = ST_SCAN_RD;
      end
      ST_DECIDE: begin
        if (!cur.blocked) state_next = ST_DONE;
        else if (has_prev && has_next) begin
          state_next = (idx + 1'b1 < cnt) ? ST_SHIFT_RD : ST_FULL_RD;
        end else if (has_prev || has_next) state_next = ST_FULL_RD;
        else if (cnt >= CW'(MAX_SHADOWS)) state_next = ST_DONE;
        else state_next = (cnt > idx_eff) ? ST_SHIFT_RD : ST_INS;
      end
      ST_SHIFT_RD: state_next = ST_SHIFT_WR;
      ST_SHIFT_WR: begin
        if (dn) state_next = (i + 1'b1 < cnt) ? ST_SHIFT_RD : ST_FULL_RD;
        else state_next = (i - 1'b1 > idx) ? ST_SHIFT_RD : ST_INS;
      end
      ST_INS:      state_next = ST_FULL_RD;
      ST_FULL_RD:  state_next = ST_FULL_CHK;
      ST_FULL_CHK: state_next = ST_DONE;
      ST_DONE:     state_next = res_load ? ST_IDLE : ST_DONE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = (state == ST_IDLE);
    raddr   = i[AW-1:0];
    we      = 1'b0;
    waddr   = i[AW-1:0];
    wdata   = rdata;
    case (state)
      ST_SCAN_RD: raddr = i[AW-1:0];
      ST_DECIDE: begin
        if (cur.blocked && (has_prev || has_next)) begin
          we = 1'b1;
          if (has_prev && has_next) begin
            waddr = AW'(idx_eff - 1'b1);
            wdata = '{prev_e.lo_n, prev_e.lo_d, next_e.hi_n, next_e.hi_d};
          end else if (has_next) begin
            waddr = idx_eff[AW-1:0];
            wdata = '{cur.span.lo_n, cur.span.lo_d, next_e.hi_n, next_e.hi_d};
          end else begin
            waddr = AW'(idx_eff - 1'b1);
            wdata = '{prev_e.lo_n, prev_e.lo_d, cur.span.hi_n, cur.span.hi_d};
          end
        end
      end
      ST_SHIFT_RD: raddr = dn ? AW'(i + 1'b1) : AW'(i - 1'b1);
      ST_SHIFT_WR: begin
        we    = 1'b1;
        waddr = i[AW-1:0];
        wdata = rdata;
      end
      ST_INS: begin
        we    = 1'b1;
        waddr = idx[AW-1:0];
        wdata = cur.span;
      end
      ST_FULL_RD: raddr = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur   <= q_data;
      i     <= '0;
      found <= 1'b0;
      vis   <= 1'b0;
      ovf   <= 1'b0;
    end
    if (state == ST_SCAN_CHK) begin
      if (!found && at_lo) begin
        found  <= 1'b1;
        idx    <= i;
        next_e <= rdata;
      end else if (!found) begin
        prev_e <= rdata;
      end
      i <= i + 1'b1;
    end
    if (state == ST_DECIDE) begin
      vis <= 1'b1;
      idx <= idx_eff;
      if (has_prev && has_next) begin
        dn <= 1'b1;
        i  <= idx_eff;
      end else if (!has_prev && !has_next) begin
        dn <= 1'b0;
        i  <= cnt;
        if (cur.blocked && cnt >= CW'(MAX_SHADOWS)) ovf <= 1'b1;
      end
    end
    if (state == ST_SHIFT_WR) begin
      i <= dn ? i + 1'b1 : i - 1'b1;
    end
    if (res_load) begin
      res_out.visible        <= vis;
      res_out.offset_x       <= cur.off_x;
      res_out.offset_y       <= cur.off_y;
      res_out.fully_shadowed <= full;
      res_out.list_overflow  <= ovf;
    end
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      full      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (take && q_data.start) begin
        cnt  <= '0;
        full <= 1'b0;
      end
      if (state == ST_DECIDE && cur.blocked) begin
        if (has_prev && has_next) cnt <= cnt - 1'b1;
        else if (!has_prev && !has_next && cnt < CW'(MAX_SHADOWS)) cnt <= cnt + 1'b1;
      end
      if (state == ST_FULL_CHK) begin
        full <= (cnt == CW'(1)) && (rdata.lo_n == '0) && (rdata.hi_n == rdata.hi_d);
      end
      if (res_load) res_valid <= 1'b1;
      else if (res_out.ready) res_valid <= 1'b0;
    end
  end

  assign res_out.valid = res_valid;

endmodule
`default_nettype wire

// ----- sv/svo_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svo_port_checks: port-level checks
// Result channel behavior seen from the top level ports.
// ----------------------------------------------------------------------------
module svo_port_checks (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       visible,
  input wire logic       fully_shadowed,
  input wire logic       list_overflow
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(visible) && $stable(list_overflow))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_ovf_vis: assert property (@(posedge clk) disable iff (rst)
    out_valid && list_overflow |-> visible && !fully_shadowed)
    else $error("overflow on a hidden tile or under full shadow");

endmodule

bind shadowcast_visibility_octant svo_port_checks u_chk (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (res_out.valid),
  .out_ready      (res_out.ready),
  .visible        (res_out.visible),
  .fully_shadowed (res_out.fully_shadowed),
  .list_overflow  (res_out.list_overflow)
);
`default_nettype wire
